/* sv/gelu_pkg.sv */
package gelu_pkg;

    // Defaults for the top level parameters
    localparam int DEF_DATA_WIDTH = 16;
    localparam int DEF_FRAC_BITS  = 12;

    // Internal fixed point: the tanh argument path is Q.16
    localparam int TQ         = 16;
    localparam int SEG_SHIFT  = 14;
    localparam int SEG_COUNT  = 24;
    localparam int COEF_SHIFT = 24;

    // Widths of the argument path, fixed by the clamp to +/-8 in Q.16
    localparam int XC_W    = 21;
    localparam int SQ_W    = 24;
    localparam int CUBE_W  = 27;
    localparam int INNER_W = 23;
    localparam int U_W     = 22;
    localparam int TAB_W   = 16;
    localparam int T_W     = 18;
    localparam int SEG_W   = 5;

    // 0.044715 and sqrt(2/pi) scaled by 2^24
    localparam int CC_W = 21;
    localparam int SC_W = 25;
    localparam logic signed [CC_W-1:0] CUBE_COEF  = 21'sd750193;
    localparam logic signed [SC_W-1:0] SCALE_COEF = 25'sd13386282;

    typedef struct packed {
        logic en_seg;
        logic en_interp;
    } t_pwl_ctrl;

    // tanh at steps of 0.25 over [0, 6], Q.16
    function automatic logic [TAB_W-1:0] tanh_tab(input logic [SEG_W-1:0] idx);
        logic [TAB_W-1:0] v;
        unique case (idx)
            5'd0:    v = 16'd0;
            5'd1:    v = 16'd16051;
            5'd2:    v = 16'd30285;
            5'd3:    v = 16'd41625;
            5'd4:    v = 16'd49912;
            5'd5:    v = 16'd55593;
            5'd6:    v = 16'd59320;
            5'd7:    v = 16'd61694;
            5'd8:    v = 16'd63179;
            5'd9:    v = 16'd64096;
            5'd10:   v = 16'd64659;
            5'd11:   v = 16'd65003;
            5'd12:   v = 16'd65212;
            5'd13:   v = 16'd65339;
            5'd14:   v = 16'd65417;
            5'd15:   v = 16'd65464;
            5'd16:   v = 16'd65492;
            5'd17:   v = 16'd65509;
            5'd18:   v = 16'd65520;
            5'd19:   v = 16'd65526;
            5'd20:   v = 16'd65530;
            5'd21:   v = 16'd65532;
            5'd22:   v = 16'd65534;
            default: v = 16'd65535;
        endcase
        return v;
    endfunction

endpackage

/* sv/gelu_tanh_pwl.sv */
module gelu_tanh_pwl (
    input  logic                                i_clk,
    input  gelu_pkg::t_pwl_ctrl                 i_ctrl,
    input  logic signed [gelu_pkg::U_W-1:0]     i_u,
    output logic signed [gelu_pkg::T_W-1:0]     o_t
);

    localparam int A_W    = gelu_pkg::U_W - 1;
    localparam int SEGF_W = A_W - gelu_pkg::SEG_SHIFT;
    localparam int TAB_W  = gelu_pkg::TAB_W;
    localparam int FR_W   = gelu_pkg::SEG_SHIFT;
    localparam int IP_W   = TAB_W + FR_W;
    localparam int MAG_W  = gelu_pkg::TQ + 1;
    localparam logic [MAG_W-1:0] FULL_SCALE = MAG_W'(1) << gelu_pkg::TQ;

    logic                            w_neg;
    logic [gelu_pkg::U_W-1:0]        w_abs;
    logic [SEGF_W-1:0]               w_segf;
    logic [gelu_pkg::SEG_W-1:0]      w_seg;
    logic [TAB_W-1:0]                w_lo;
    logic [TAB_W-1:0]                w_hi;

    logic [TAB_W-1:0]                r_lo;
    logic [TAB_W-1:0]                r_diff;
    logic [FR_W-1:0]                 r_fr;
    logic                            r_sat;
    logic                            r_neg;

    logic [IP_W-1:0]                 w_ip;
    logic [MAG_W-1:0]                w_mag;
    logic signed [gelu_pkg::T_W-1:0] w_t;
    logic signed [gelu_pkg::T_W-1:0] r_t;

    // Segment lookup: magnitude, segment index, both table ends
    assign w_neg  = i_u[gelu_pkg::U_W-1];
    assign w_abs  = w_neg ? gelu_pkg::U_W'(-i_u) : gelu_pkg::U_W'(i_u);
    assign w_segf = w_abs[A_W-1:gelu_pkg::SEG_SHIFT];
    assign w_seg  = w_segf[gelu_pkg::SEG_W-1:0];
    assign w_lo   = gelu_pkg::tanh_tab(w_seg);
    assign w_hi   = gelu_pkg::tanh_tab(gelu_pkg::SEG_W'(w_seg + gelu_pkg::SEG_W'(1)));

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en_seg) begin
            r_lo   <= w_lo;
            r_diff <= w_hi - w_lo;
            r_fr   <= w_abs[FR_W-1:0];
            r_sat  <= (w_segf >= SEGF_W'(gelu_pkg::SEG_COUNT));
            r_neg  <= w_neg;
        end
    end

    // Interpolate within the segment and restore the sign
    assign w_ip  = IP_W'(r_diff) * IP_W'(r_fr);
    assign w_mag = r_sat ? FULL_SCALE
                         : MAG_W'(r_lo) + MAG_W'(w_ip[IP_W-1:FR_W]);
    assign w_t   = r_neg ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en_interp) begin
            r_t <= w_t;
        end
    end

    assign o_t = r_t;

endmodule

/* sv/gelu_tanh_activation_top.sv */
// GELU activation, tanh form, one sample per clock.
//   y = 0.5 * x * (1 + tanh(sqrt(2/pi) * (x + 0.044715 * x^3)))
// Input stream (s_axis): tdata carries x, signed, FRAC_BITS fraction bits,
// tlast marks the final element of a vector. Output stream (m_axis): tdata
// carries y in the same format, saturated to DATA_WIDTH bits, tlast is the
// input mark passed through unchanged. No state is kept between samples.
// An accepted request reaches m_axis through nine register stages: align,
// square, cube, inner sum, tanh argument, segment lookup, interpolation,
// final product, rounding.
// No stage holds more than one multiplier, none wider than about 32 by 32.
// Throughput: one sample per clock, sustained while m_axis_tready is high.
// When the receiver stalls, the output register holds its result and the
// stages behind it fill up; empty stages keep accepting, so s_axis_tready
// only drops once all nine stages hold a sample. s_axis_tready follows
// m_axis_tready combinationally through the stage enables.
// Reset (i_rst_n low, synchronous) empties every stage; nothing is lost or
// repeated across a stall.
module gelu_tanh_activation_top #(
    parameter int DATA_WIDTH = gelu_pkg::DEF_DATA_WIDTH,
    parameter int FRAC_BITS  = gelu_pkg::DEF_FRAC_BITS,
    localparam int TDATA_W   = ((DATA_WIDTH + 7) / 8) * 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [TDATA_W-1:0] s_axis_tdata,   // [DATA_WIDTH-1:0] x_value, rest zero
    input  logic               s_axis_tlast,   // last_in
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,   // [DATA_WIDTH-1:0] y_value, rest zero
    output logic               m_axis_tlast    // last_out
);

    localparam int NSTG    = 9;
    localparam int XE_W    = (DATA_WIDTH > FRAC_BITS + 5) ? DATA_WIDTH : FRAC_BITS + 5;
    localparam int AL_W    = XE_W + gelu_pkg::TQ;
    localparam int SHL     = (FRAC_BITS <= gelu_pkg::TQ) ? gelu_pkg::TQ - FRAC_BITS : 0;
    localparam int SHR     = (FRAC_BITS > gelu_pkg::TQ) ? FRAC_BITS - gelu_pkg::TQ : 0;
    localparam int XC_W    = gelu_pkg::XC_W;
    localparam int SQ_W    = gelu_pkg::SQ_W;
    localparam int CUBE_W  = gelu_pkg::CUBE_W;
    localparam int INNER_W = gelu_pkg::INNER_W;
    localparam int U_W     = gelu_pkg::U_W;
    localparam int T_W     = gelu_pkg::T_W;
    localparam int SQP_W   = 2 * XC_W;
    localparam int CP_W    = SQ_W + XC_W;
    localparam int CCP_W   = CUBE_W + gelu_pkg::CC_W;
    localparam int SCP_W   = INNER_W + gelu_pkg::SC_W;
    localparam int F_W     = T_W + 1;
    localparam int PROD_W  = DATA_WIDTH + F_W;
    localparam int YS_W    = PROD_W - gelu_pkg::TQ - 1;

    localparam logic signed [XE_W-1:0]       LIM     = XE_W'(8) << FRAC_BITS;
    localparam logic signed [XE_W-1:0]       NEG_LIM = -LIM;
    localparam logic signed [F_W-1:0]        ONE_Q   = F_W'(1) << gelu_pkg::TQ;
    localparam logic signed [T_W-1:0]        T_MAX   = T_W'(1) << gelu_pkg::TQ;
    localparam logic signed [T_W-1:0]        T_MIN   = -T_MAX;
    localparam logic signed [DATA_WIDTH-1:0] Y_MAX   = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] Y_MIN   = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // Stage valid bits and enables
    logic [NSTG-1:0]  r_vld;
    logic [NSTG-1:0]  w_en;
    logic             r_last [NSTG];
    logic signed [DATA_WIDTH-1:0] r_x [NSTG-2];

    // Argument path registers
    logic signed [XC_W-1:0]    r_xc0;
    logic signed [XC_W-1:0]    r_xc1;
    logic signed [XC_W-1:0]    r_xc2;
    logic signed [SQ_W-1:0]    r_sq1;
    logic signed [CUBE_W-1:0]  r_cube2;
    logic signed [INNER_W-1:0] r_inner3;
    logic signed [U_W-1:0]     r_u4;
    logic signed [PROD_W-1:0]  r_prod7;
    logic signed [DATA_WIDTH-1:0] r_y8;

    logic signed [DATA_WIDTH-1:0] w_x_in;
    logic signed [XE_W-1:0]       w_xe;
    logic signed [XE_W-1:0]       w_xcl;
    logic signed [AL_W-1:0]       w_xal;
    logic signed [SQP_W-1:0]      w_sqp;
    logic signed [CP_W-1:0]       w_cp;
    logic signed [CCP_W-1:0]      w_ccp;
    logic signed [INNER_W-1:0]    w_term;
    logic signed [SCP_W-1:0]      w_scp;
    logic signed [T_W-1:0]        w_t;
    logic signed [F_W-1:0]        w_f;
    logic signed [PROD_W-1:0]     w_prod;
    logic signed [PROD_W-1:0]     w_rnd;
    logic signed [YS_W-1:0]       w_ys;
    logic signed [DATA_WIDTH-1:0] w_y;
    gelu_pkg::t_pwl_ctrl          w_pwl_ctrl;

    // A stage advances when it is empty or the stage after it advances
    always_comb begin
        w_en[NSTG-1] = !r_vld[NSTG-1] || m_axis_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign s_axis_tready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Carry the mark and the raw sample alongside the data
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_last[0] <= s_axis_tlast;
            r_x[0]    <= w_x_in;
        end
        for (int k = 1; k < NSTG; k++) begin
            if (w_en[k]) begin
                r_last[k] <= r_last[k-1];
            end
        end
        for (int k = 1; k < NSTG - 2; k++) begin
            if (w_en[k]) begin
                r_x[k] <= r_x[k-1];
            end
        end
    end

    // Stage 0: clamp to +/-8 and align to Q.16
    assign w_x_in = s_axis_tdata[DATA_WIDTH-1:0];
    assign w_xe   = XE_W'(w_x_in);
    assign w_xcl  = (w_xe > LIM) ? LIM : ((w_xe < NEG_LIM) ? NEG_LIM : w_xe);
    assign w_xal  = (AL_W'(w_xcl) <<< SHL) >>> SHR;

    // Stages 1 to 4: square, cube, inner sum, scaled argument
    assign w_sqp  = SQP_W'(r_xc0) * SQP_W'(r_xc0);
    assign w_cp   = CP_W'(r_sq1) * CP_W'(r_xc1);
    assign w_ccp  = CCP_W'(r_cube2) * CCP_W'(gelu_pkg::CUBE_COEF);
    assign w_term = w_ccp[gelu_pkg::COEF_SHIFT+INNER_W-1:gelu_pkg::COEF_SHIFT];
    assign w_scp  = SCP_W'(r_inner3) * SCP_W'(gelu_pkg::SCALE_COEF);

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_xc0 <= w_xal[XC_W-1:0];
        end
        if (w_en[1]) begin
            r_sq1 <= w_sqp[gelu_pkg::TQ+SQ_W-1:gelu_pkg::TQ];
            r_xc1 <= r_xc0;
        end
        if (w_en[2]) begin
            r_cube2 <= w_cp[gelu_pkg::TQ+CUBE_W-1:gelu_pkg::TQ];
            r_xc2   <= r_xc1;
        end
        if (w_en[3]) begin
            r_inner3 <= INNER_W'(r_xc2) + w_term;
        end
        if (w_en[4]) begin
            r_u4 <= w_scp[gelu_pkg::COEF_SHIFT+U_W-1:gelu_pkg::COEF_SHIFT];
        end
    end

    // Stages 5 and 6: piecewise-linear tanh
    assign w_pwl_ctrl.en_seg    = w_en[5];
    assign w_pwl_ctrl.en_interp = w_en[6];

    gelu_tanh_pwl u_tanh (
        .i_clk  (i_clk),
        .i_ctrl (w_pwl_ctrl),
        .i_u    (r_u4),
        .o_t    (w_t)
    );

    // Stage 7: x * (1 + tanh), stage 8: round half up and saturate
    assign w_f    = F_W'(w_t) + ONE_Q;
    assign w_prod = PROD_W'(r_x[NSTG-3]) * PROD_W'(w_f);
    assign w_rnd  = r_prod7 + PROD_W'(ONE_Q);
    assign w_ys   = w_rnd[PROD_W-1:gelu_pkg::TQ+1];
    assign w_y    = (w_ys > YS_W'(Y_MAX)) ? Y_MAX :
                    ((w_ys < YS_W'(Y_MIN)) ? Y_MIN : w_ys[DATA_WIDTH-1:0]);

    always_ff @(posedge i_clk) begin
        if (w_en[7]) begin
            r_prod7 <= w_prod;
        end
        if (w_en[8]) begin
            r_y8 <= w_y;
        end
    end

    assign m_axis_tvalid = r_vld[NSTG-1];
    assign m_axis_tdata  = TDATA_W'($unsigned(r_y8));
    assign m_axis_tlast  = r_last[NSTG-1];

`ifndef SYNTHESIS
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> (!m_axis_tvalid && s_axis_tready))
        else $error("pipeline not empty after reset");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (&r_vld))
        else $error("input stalled while a stage is empty");

    a_tanh_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[6] |-> (w_t <= T_MAX && w_t >= T_MIN))
        else $error("tanh value outside +/-1");

    a_request_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> r_vld[0])
        else $error("accepted request lost at the first stage");
`endif

endmodule

/* tb/gelu_checker.sv */
module gelu_checker #(
    parameter int DW  = 16,
    parameter int FB  = 12,
    parameter int TDW = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    input  logic           i_s_tready,
    input  logic [TDW-1:0] i_s_tdata,   // [DW-1:0] x_value, rest zero
    input  logic           i_s_tlast,   // last_in
    input  logic           i_m_tvalid,
    input  logic           i_m_tready,
    input  logic [TDW-1:0] i_m_tdata,   // [DW-1:0] y_value, rest zero
    input  logic           i_m_tlast,   // last_out
    output int             o_fail_count,
    output int             o_pending,
    output int             o_result_count
);

    // tanh at steps of 0.25 over [0, 6], Q.16
    localparam int TANH_KNOTS [0:24] = '{
            0, 16051, 30285, 41625, 49912, 55593, 59320, 61694,
        63179, 64096, 64659, 65003, 65212, 65339, 65417, 65464,
        65492, 65509, 65520, 65526, 65530, 65532, 65534, 65535,
        65535
    };

    typedef struct {
        logic [DW-1:0] x;
        logic [DW-1:0] y;
        logic          last;
    } t_gelu_due;

    t_gelu_due results_due [$];
    t_gelu_due due;
    int        fails = 0;
    int        n_results = 0;

    // Arithmetic shifts on longint floor towards minus infinity throughout
    function automatic logic [DW-1:0] gelu_of(input logic [DW-1:0] raw);
        longint x, lim, xcl, xc, sq, cube, inner, u, a, seg, t, lo, hi, prod, y, ymax;
        x    = longint'($signed(raw));
        lim  = longint'(8) <<< FB;
        xcl  = (x > lim) ? lim : ((x < -lim) ? -lim : x);
        xc   = (FB <= 16) ? (xcl <<< (16 - FB)) : (xcl >>> (FB - 16));
        sq   = (xc * xc) >>> 16;
        cube = (sq * xc) >>> 16;
        inner = xc + ((cube * longint'(750193)) >>> 24);
        u    = (inner * longint'(13386282)) >>> 24;
        a    = (u < 0) ? -u : u;
        seg  = a >>> 14;
        if (seg >= 24) begin
            t = longint'(65536);
        end else begin
            lo = TANH_KNOTS[seg];
            hi = TANH_KNOTS[seg + 1];
            t  = lo + (((hi - lo) * (a & longint'(16383))) >>> 14);
        end
        if (u < 0) begin
            t = -t;
        end
        prod = x * (longint'(65536) + t);
        y    = (prod + longint'(65536)) >>> 17;
        ymax = (longint'(1) <<< (DW - 1)) - 1;
        if (y > ymax) begin
            y = ymax;
        end
        if (y < -ymax - 1) begin
            y = -ymax - 1;
        end
        return DW'(y);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            results_due.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                due.x    = i_s_tdata[DW-1:0];
                due.y    = gelu_of(i_s_tdata[DW-1:0]);
                due.last = i_s_tlast;
                results_due.push_back(due);
            end
            if (i_m_tvalid && i_m_tready) begin
                n_results++;
                if (results_due.size() == 0) begin
                    fails++;
                    if (fails <= 10) begin
                        $display("unexpected result: y=%0d last=%b",
                                 $signed(i_m_tdata[DW-1:0]), i_m_tlast);
                    end
                end else begin
                    due = results_due.pop_front();
                    if (i_m_tdata !== TDW'(due.y) || i_m_tlast !== due.last) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("x=%0d: expected y=%0d last=%b, got y=%0d last=%b",
                                     $signed(due.x), $signed(due.y), due.last,
                                     $signed(i_m_tdata[DW-1:0]), i_m_tlast);
                        end
                    end
                end
            end
        end
        o_pending      <= results_due.size();
        o_fail_count   <= fails;
        o_result_count <= n_results;
    end

endmodule

/* tb/tb.sv */
module tb;

    localparam int DW  = gelu_pkg::DEF_DATA_WIDTH;
    localparam int FB  = gelu_pkg::DEF_FRAC_BITS;
    localparam int TDW = ((DW + 7) / 8) * 8;

    // Idle cycles tolerated before the run is declared hung
    localparam int WATCHDOG_LIMIT = 4000;
    // Long output hold-off, well beyond the nine pipeline stages
    localparam int LONG_HOLD      = 200;
    // Settle time after the last expected result
    localparam int DRAIN_CYCLES   = 30;

    // Extremes, signs, the tanh knee and its saturated tail, bit patterns
    localparam logic [15:0] DIRECTED_X [0:21] = '{
        16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h1000,
        16'hF000, 16'h2000, 16'hE000, 16'h3000, 16'hD000, 16'h4800,
        16'hB800, 16'h0800, 16'hF800, 16'h0400, 16'hFC00, 16'h7000,
        16'h9000, 16'h5555, 16'hAAAA, 16'h3A00
    };

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           s_axis_tvalid = 1'b0;
    logic           s_axis_tready;
    logic [TDW-1:0] s_axis_tdata = '0;   // [DW-1:0] x_value, rest zero
    logic           s_axis_tlast = 1'b0; // last_in
    logic           m_axis_tvalid;
    logic           m_axis_tready = 1'b0;
    logic [TDW-1:0] m_axis_tdata;        // [DW-1:0] y_value, rest zero
    logic           m_axis_tlast;        // last_out

    int fail_count;
    int pending;
    int result_count;

    // Test controls and counters for the request side, the result side and the watchdog
    bit gaps_on = 1'b1;
    bit stalls_on = 1'b1;
    bit long_hold_req = 1'b0;
    int n_sent = 0;
    int n_ends = 0;
    int idle_cycles = 0;

    gelu_tanh_activation_top #(
        .DATA_WIDTH (DW),
        .FRAC_BITS  (FB)
    ) u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Predict and compare beside the block
    gelu_checker #(
        .DW  (DW),
        .FB  (FB),
        .TDW (TDW)
    ) u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_tvalid     (s_axis_tvalid),
        .i_s_tready     (s_axis_tready),
        .i_s_tdata      (s_axis_tdata),
        .i_s_tlast      (s_axis_tlast),
        .i_m_tvalid     (m_axis_tvalid),
        .i_m_tready     (m_axis_tready),
        .i_m_tdata      (m_axis_tdata),
        .i_m_tlast      (m_axis_tlast),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // Offer one request and hold it until accepted, then maybe idle a burst
    task automatic send_sample(input logic [DW-1:0] x, input logic last);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= TDW'(x);
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready) begin
            @(posedge clk);
        end
        n_sent++;
        if (last) begin
            n_ends++;
        end
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Weight the samples towards the curved part of the function
    function automatic logic [DW-1:0] pick_sample();
        int unsigned sel;
        int one;
        sel = $urandom_range(0, 9);
        one = 1 << FB;
        if (sel <= 3) begin
            return DW'($urandom());
        end else if (sel <= 7) begin
            return DW'(int'($urandom_range(0, 8 * one)) - 4 * one);
        end else if (sel == 8) begin
            return DW'(int'($urandom_range(0, 128)) - 64);
        end
        case ($urandom_range(0, 3))
            0:       return {1'b0, {(DW-1){1'b1}}};
            1:       return {1'b1, {(DW-1){1'b0}}};
            2:       return {DW{1'b1}};
            default: return DW'(1);
        endcase
    endfunction

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++) begin
            send_sample(pick_sample(), $urandom_range(0, 7) == 0);
        end
    endtask

    // Result side: random stall bursts, one long hold-off on request
    initial begin
        @(posedge clk);
        forever begin
            if (long_hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold_req = 1'b0;
            end else if (stalls_on && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Count cycles with no accepted request and no accepted result
    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d results still due",
                     idle_cycles, pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners, a vector end every few samples
        for (int i = 0; i < $size(DIRECTED_X); i++) begin
            send_sample(DW'(DIRECTED_X[i]), (i % 4) == 3);
        end

        // Pause the request side until every result has come back
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end

        // Hold the output off while requests keep coming, filling the pipeline
        gaps_on = 1'b0;
        long_hold_req = 1'b1;
        send_random(40);

        // Main random body, idling switched on and off in stretches
        for (int blk = 0; blk < 12; blk++) begin
            gaps_on   = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            send_random(100);
        end

        // Closing stretch at full rate on both sides
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        send_random(150);

        // Drain
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d samples (%0d vector ends) and %0d results,", n_sent, n_ends,
                 result_count);
        $display("with directed corners, a long output hold-off and a full drain pause.");
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d failures counted", fail_count);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
